/* design/dds_pkg.sv */
package dds_pkg;

  localparam int TABLE_BITS  = 12;
  localparam int PHASE_WIDTH = 32;
  localparam int ADDR_BITS   = TABLE_BITS + 1;
  localparam int TABLE_DEPTH = 1 << ADDR_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_BITS  = 2;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_STEP_A  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_STEP_B  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_WORD_A   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_WORD_B   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AC_ENABLE     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_ENABLE  = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_TICKS   = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BURST_CHANNEL = 3'd7;

  localparam logic [15:0] IDLE_WORD_A_RESET = 16'd14346;
  localparam logic [15:0] IDLE_WORD_B_RESET = 16'd47097;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_IDLE  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic        table_channel;
    logic [11:0] table_index;
    logic [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dac_word;
    logic        dac_channel;
  } out_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  channel;
    logic [TABLE_BITS-1:0] index;
    logic [15:0]           data;
  } queue_op_t;

endpackage

/* design/dds_ram.sv */
module dds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/dds_front.sv */
module dds_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  logic                               item_ready,
  input  dds_pkg::in_item_t                  item,
  input  logic                               cfg_write,
  input  logic [dds_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dds_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic                               push,
  output dds_pkg::queue_op_t                 push_op
);
  import dds_pkg::*;

  logic [31:0]            phase_step_a;
  logic [31:0]            phase_step_b;
  logic [15:0]            idle_word_a;
  logic [15:0]            idle_word_b;
  logic                   ac_enable;
  logic                   burst_enable;
  logic [15:0]            burst_ticks;
  logic [PHASE_WIDTH-1:0] phase_a;
  logic [PHASE_WIDTH-1:0] phase_b;
  logic                   toggle;
  logic                   playing;
  logic [15:0]            burst_remaining;

  logic                   accept;
  logic                   is_tick;
  logic                   emits;
  logic                   ac_tick;
  logic [PHASE_WIDTH-1:0] phase_sum;
  logic [15:0]            burst_dec;

  assign accept    = item_valid && item_ready;
  assign is_tick   = item.mode == MODE_TICK;
  assign emits     = is_tick && !(playing && !ac_enable);
  assign ac_tick   = is_tick && playing && ac_enable;
  assign phase_sum = toggle ? phase_b + PHASE_WIDTH'(phase_step_b)
                            : phase_a + PHASE_WIDTH'(phase_step_a);
  assign burst_dec = burst_remaining - 16'd1;

  always_comb begin
    push_op = '0;
    push    = 1'b0;
    if (accept) begin
      if (item.mode == MODE_WRITE) begin
        push            = 1'b1;
        push_op.kind    = OP_WRITE;
        push_op.channel = item.table_channel;
        push_op.index   = TABLE_BITS'(item.table_index);
        push_op.data    = item.table_value;
      end else if (emits) begin
        push            = 1'b1;
        push_op.channel = toggle;
        if (playing) begin
          push_op.kind  = OP_READ;
          push_op.index = phase_sum[PHASE_WIDTH-1 -: TABLE_BITS];
        end else begin
          push_op.kind  = OP_IDLE;
          push_op.data  = toggle ? idle_word_b : idle_word_a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step_a    <= '0;
      phase_step_b    <= '0;
      idle_word_a     <= IDLE_WORD_A_RESET;
      idle_word_b     <= IDLE_WORD_B_RESET;
      ac_enable       <= 1'b0;
      burst_enable    <= 1'b0;
      burst_ticks     <= '0;
      phase_a         <= '0;
      phase_b         <= '0;
      toggle          <= 1'b0;
      playing         <= 1'b0;
      burst_remaining <= '0;
    end else begin
      if (accept) begin
        unique case (item.mode)
          MODE_RUN:  playing <= 1'b1;
          MODE_STOP: playing <= 1'b0;
          default: ;
        endcase
        if (emits) begin
          toggle <= ~toggle;
        end
        if (ac_tick) begin
          if (toggle) begin
            phase_b <= phase_sum;
          end else begin
            phase_a <= phase_sum;
          end
          if (burst_enable) begin
            if (burst_dec == '0) begin
              playing         <= 1'b0;
              burst_remaining <= burst_ticks;
            end else begin
              burst_remaining <= burst_dec;
            end
          end
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PHASE_STEP_A: phase_step_a <= cfg_data[31:0];
          REG_PHASE_STEP_B: phase_step_b <= cfg_data[31:0];
          REG_IDLE_WORD_A:  idle_word_a  <= cfg_data[15:0];
          REG_IDLE_WORD_B:  idle_word_b  <= cfg_data[15:0];
          REG_AC_ENABLE:    ac_enable    <= cfg_data[0];
          REG_BURST_ENABLE: burst_enable <= cfg_data[0];
          REG_BURST_TICKS: begin
            burst_ticks     <= cfg_data[15:0];
            burst_remaining <= cfg_data[15:0];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* design/dds_queue.sv */
module dds_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dds_pkg::queue_op_t push_op,
  output logic               not_full,
  input  logic               pop,
  output logic               head_valid,
  output dds_pkg::queue_op_t head_op
);
  import dds_pkg::*;

  queue_op_t             entries [QUEUE_DEPTH];
  logic [QUEUE_BITS-1:0] head;
  logic [QUEUE_BITS-1:0] tail;
  logic [QUEUE_BITS:0]   count;

  assign not_full   = count != (QUEUE_BITS + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/dds_back.sv */
module dds_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  dds_pkg::queue_op_t  head_op,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output dds_pkg::out_item_t  result
);
  import dds_pkg::*;

  logic                 s1_valid;
  logic                 s1_read;
  logic                 s1_channel;
  logic [15:0]          s1_word;
  logic                 s1_adv;
  logic                 s1_free;
  logic                 is_write;
  logic                 wr_en;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] addr;
  logic [15:0]          rd_data;

  assign is_write = head_op.kind == OP_WRITE;
  assign s1_adv   = s1_valid && (!result_valid || result_ready);
  assign s1_free  = !s1_valid || s1_adv;
  assign pop      = head_valid && (is_write || s1_free);
  assign wr_en    = pop && is_write;
  assign rd_en    = pop && head_op.kind == OP_READ;
  assign addr     = {head_op.channel, head_op.index};

  dds_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (head_op.data),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (pop && !is_write) begin
      s1_read    <= head_op.kind == OP_READ;
      s1_channel <= head_op.channel;
      s1_word    <= head_op.data;
    end
    if (s1_adv) begin
      result.dac_word    <= s1_read ? rd_data : s1_word;
      result.dac_channel <= s1_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= (s1_valid && !s1_adv) || (pop && !is_write);
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/dual_channel_dds_generator_top.sv */
// Channel   Handshake                    Payload
// item      item_valid / item_ready      item   (mode, table_channel, table_index, table_value)
// result    result_valid / result_ready  result (dac_word, dac_channel)
// config    cfg_write, cfg_index         cfg_data, written with no wait
//
// One item per cycle sustained while item_ready is high; a tick's sample becomes valid
// after the queue write at the accepting edge, the table read and the output register.
// Four-entry queue between front and back; the table RAM has one read port.
// Synchronous reset; table contents are not cleared and must be written first.
// A stalled output backs up through the queue before item_ready drops.
module dual_channel_dds_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  dds_pkg::in_item_t                   item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output dds_pkg::out_item_t                  result,
  input  logic                                cfg_write,
  input  logic [dds_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dds_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import dds_pkg::*;

  logic      push;
  queue_op_t push_op;
  logic      pop;
  logic      head_valid;
  queue_op_t head_op;

  dds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_op    (push_op)
  );

  dds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .not_full   (item_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  dds_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* bench/dds_sample_checker.sv */
module dds_sample_checker
  import dds_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  in_item_t                   item,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  out_item_t                  result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         mismatches,
  output int                         outstanding,
  output int                         samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PHASE_WIDTH-1:0] step_reg [2];
  logic [15:0]            idle_reg [2];
  logic                   ac_on;
  logic                   burst_on;
  logic                   burst_sel;
  logic [15:0]            burst_len;
  logic [15:0]            burst_left;

  logic [PHASE_WIDTH-1:0] phase_acc [2];
  logic [15:0]            wave [2][1 << TABLE_BITS];
  logic                   next_ch;
  logic                   playing;

  out_item_t              dac_due [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
    samples_checked = 0;
  end

  task automatic reset_synth();
    step_reg[0] = '0;
    step_reg[1] = '0;
    idle_reg[0] = IDLE_WORD_A_RESET;
    idle_reg[1] = IDLE_WORD_B_RESET;
    ac_on = 1'b0;
    burst_on = 1'b0;
    burst_sel = 1'b0;
    burst_len = '0;
    burst_left = '0;
    phase_acc[0] = '0;
    phase_acc[1] = '0;
    next_ch = 1'b0;
    playing = 1'b0;
    dac_due.delete();
  endtask

  task automatic write_synth_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_DATA_WIDTH-1:0] val);
    case (idx)
      REG_PHASE_STEP_A:  step_reg[0] = val[PHASE_WIDTH-1:0];
      REG_PHASE_STEP_B:  step_reg[1] = val[PHASE_WIDTH-1:0];
      REG_IDLE_WORD_A:   idle_reg[0] = val[15:0];
      REG_IDLE_WORD_B:   idle_reg[1] = val[15:0];
      REG_AC_ENABLE:     ac_on = val[0];
      REG_BURST_ENABLE:  burst_on = val[0];
      REG_BURST_TICKS: begin
        burst_len = val[15:0];
        burst_left = val[15:0];
      end
      REG_BURST_CHANNEL: burst_sel = val[0];
      default: ;
    endcase
  endtask

  // burst_sel is held but never steers anything: one counter serves both channels
  task automatic apply_item(input in_item_t it);
    out_item_t             smp;
    logic [TABLE_BITS-1:0] addr;
    case (it.mode)
      MODE_WRITE: wave[it.table_channel][it.table_index[TABLE_BITS-1:0]] = it.table_value;
      MODE_RUN:   playing = 1'b1;
      MODE_STOP:  playing = 1'b0;
      MODE_TICK: begin
        if (!playing || ac_on) begin
          smp.dac_channel = next_ch;
          if (!playing) begin
            smp.dac_word = idle_reg[next_ch];
          end else begin
            phase_acc[next_ch] = phase_acc[next_ch] + step_reg[next_ch];
            addr = phase_acc[next_ch][PHASE_WIDTH-1 -: TABLE_BITS];
            smp.dac_word = wave[next_ch][addr];
            if (burst_on) begin
              burst_left = burst_left - 16'd1;
              if (burst_left == 16'd0) begin
                playing = 1'b0;
                burst_left = burst_len;
              end
            end
          end
          next_ch = ~next_ch;
          dac_due.push_back(smp);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_sample(input out_item_t got);
    out_item_t want;
    samples_checked++;
    if (dac_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: unexpected sample word %h ch %0d", $realtime, got.dac_word,
                 got.dac_channel);
    end else begin
      want = dac_due.pop_front();
      if (got.dac_word !== want.dac_word || got.dac_channel !== want.dac_channel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: sample %0d expected word %h ch %0d, got word %h ch %0d",
                   $realtime, samples_checked, want.dac_word, want.dac_channel,
                   got.dac_word, got.dac_channel);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_synth();
    end else begin
      if (result_valid && result_ready) check_sample(result);
      if (cfg_write) write_synth_reg(cfg_index, cfg_data);
      if (item_valid && item_ready) apply_item(item);
    end
    outstanding = dac_due.size();
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dds_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 95;
  localparam int FILL_STRIDE   = 64;
  // steps are whole multiples of 2^26, so playback only reaches every 64th entry
  localparam logic [31:0] STEP_MASK = 32'hFC00_0000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_ready;
  in_item_t                   item = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  out_item_t                  result;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int samples_checked;

  bit          no_gaps = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          table_writes = 0;
  int          settings_used = 0;
  logic [31:0] reg_plan [8];

  dual_channel_dds_generator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dds_sample_checker sample_chk (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .samples_checked (samples_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d samples outstanding", cycle_count,
               outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // DAC side back-pressure
  always @(posedge clk) begin
    if (no_gaps) begin
      result_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left <= gap_len();
    end
  end

  function automatic in_item_t cmd_item(input logic [1:0] m);
    in_item_t    it;
    logic [31:0] bits;
    bits = $urandom;
    it.mode = m;
    it.table_channel = bits[28];
    it.table_index = bits[27:16];
    it.table_value = bits[15:0];
    return it;
  endfunction

  function automatic in_item_t wave_item(input logic ch, input logic [11:0] idx,
                                         input logic [15:0] val);
    in_item_t it;
    it.mode = MODE_WRITE;
    it.table_channel = ch;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return cmd_item(MODE_TICK);
    if (r < 72) return cmd_item(MODE_RUN);
    if (r < 78) return cmd_item(MODE_STOP);
    return cmd_item(MODE_WRITE);
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return STEP_MASK;
      2: return $urandom_range(1, 63) << 26;
      3: return 32'h0400_0000;
      4: return 32'h8000_0000;
      default: return $urandom & STEP_MASK;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000;
      1: return 32'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_burst_len();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF;
      3: return $urandom_range(0, 65535);
      default: return $urandom_range(2, 20);
    endcase
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    if (it.mode == MODE_WRITE) table_writes++;
  endtask

  // drain: queued commands produce no sample, so hold off a little longer
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input bit [7:0] mask);
    int r;
    for (r = 0; r <= REG_BURST_CHANNEL; r++) begin
      if (mask[r]) begin
        cfg_write <= 1'b1;
        cfg_index <= r[CFG_INDEX_WIDTH-1:0];
        cfg_data <= reg_plan[r];
        @(posedge clk);
      end
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int      ch;
    int      idx;
    int      p;
    int      n;
    bit [7:0] mask;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stopped ticks with reset idle words, then playing with AC off
    repeat (3) send(cmd_item(MODE_TICK));
    send(cmd_item(MODE_RUN));
    repeat (2) send(cmd_item(MODE_TICK));
    send(cmd_item(MODE_STOP));
    send(cmd_item(MODE_TICK));

    // every entry that playback can reach gets written before any AC playback
    no_gaps = 1'b1;
    for (ch = 0; ch < 2; ch++)
      for (idx = 0; idx < (1 << TABLE_BITS); idx += FILL_STRIDE)
        send(wave_item(ch[0], idx[11:0], 16'($urandom_range(0, 65535))));
    no_gaps = 1'b0;
    send(wave_item(1'b0, 12'd0, 16'h0000));
    send(wave_item(1'b0, 12'hFC0, 16'hFFFF));
    send(wave_item(1'b1, 12'd0, 16'hFFFF));
    send(wave_item(1'b1, 12'hFC0, 16'h0000));

    // zero and near full-scale steps, extreme idle words
    settle();
    reg_plan[REG_PHASE_STEP_A] = 32'd0;
    reg_plan[REG_PHASE_STEP_B] = STEP_MASK;
    reg_plan[REG_IDLE_WORD_A] = 32'h0000;
    reg_plan[REG_IDLE_WORD_B] = 32'hFFFF;
    reg_plan[REG_AC_ENABLE] = 32'd1;
    reg_plan[REG_BURST_ENABLE] = 32'd0;
    reg_plan[REG_BURST_TICKS] = 32'd0;
    reg_plan[REG_BURST_CHANNEL] = 32'd1;
    program_regs(8'hFF);
    repeat (2) send(cmd_item(MODE_TICK));
    send(cmd_item(MODE_RUN));
    repeat (4) send(cmd_item(MODE_TICK));
    send(cmd_item(MODE_STOP));
    send(cmd_item(MODE_TICK));

    // single-tick burst ends playback on its own
    settle();
    reg_plan[REG_PHASE_STEP_A] = 32'h8000_0000;
    reg_plan[REG_BURST_ENABLE] = 32'd1;
    reg_plan[REG_BURST_TICKS] = 32'd1;
    mask = '0;
    mask[REG_PHASE_STEP_A] = 1'b1;
    mask[REG_BURST_ENABLE] = 1'b1;
    mask[REG_BURST_TICKS] = 1'b1;
    program_regs(mask);
    send(cmd_item(MODE_RUN));
    repeat (2) send(cmd_item(MODE_TICK));
    send(cmd_item(MODE_RUN));
    send(cmd_item(MODE_TICK));

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      reg_plan[REG_PHASE_STEP_A] = pick_step();
      reg_plan[REG_PHASE_STEP_B] = pick_step();
      reg_plan[REG_IDLE_WORD_A] = pick_word();
      reg_plan[REG_IDLE_WORD_B] = pick_word();
      reg_plan[REG_AC_ENABLE] = 32'($urandom_range(0, 3) != 0);
      reg_plan[REG_BURST_ENABLE] = $urandom_range(0, 1);
      reg_plan[REG_BURST_TICKS] = pick_burst_len();
      reg_plan[REG_BURST_CHANNEL] = $urandom_range(0, 1);
      mask = 8'hFF;
      // sometimes let the burst count carry over from the last setting
      if (p > 0 && $urandom_range(0, 2) == 0) mask[REG_BURST_TICKS] = 1'b0;
      program_regs(mask);
      no_gaps = (p == RAND_PHASES / 2);
      for (n = 0; n < PHASE_ITEMS; n++) send(random_item());
      no_gaps = 1'b0;
    end

    settle();
    $display("Sent %0d items (%0d table writes) across %0d register settings",
             items_sent, table_writes, settings_used);
    $display("Checked %0d DAC samples with %0d mismatches", samples_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/dds_pkg.sv
design/dds_ram.sv
design/dds_front.sv
design/dds_queue.sv
design/dds_back.sv
design/dual_channel_dds_generator_top.sv
bench/dds_sample_checker.sv
bench/tb_top.sv
